/* rtl/assert_macros.svh */
// Assertion macros shared by the keyword matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define KWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KWM_ASSERT(lbl, prop, msg)
`define KWM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/kwm_pkg.sv */
// Types and constants of the multi-keyword stream matcher.
`default_nettype none
package kwm_pkg;
	localparam int NUM_KEYS    = 32;
	localparam int MAX_KEY_LEN = 16;
	localparam int POS_WIDTH   = 32;

	localparam int KIND_W      = 2;
	localparam int SLOT_W      = 5;
	localparam int CHAR_POS_W  = 4;
	localparam int BYTE_W      = 8;
	localparam int KEY_LEN_W   = 5;
	localparam int KEY_INDEX_W = 5;
	localparam int MATCH_W     = 32;
	localparam int CFG_W       = 6;

	localparam int LEN_W     = $clog2(MAX_KEY_LEN + 1);
	localparam int TREE_LVLS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int LEAVES    = 1 << TREE_LVLS;
	localparam int IDX_W     = TREE_LVLS;

	typedef enum logic [KIND_W-1:0] {
		KIND_KEY_BYTE = 2'd0,
		KIND_KEY_LEN  = 2'd1,
		KIND_TEXT     = 2'd2
	} kind_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic                  key_wr;
		logic                  len_wr;
		logic                  text;
		logic                  sot;
		logic [CHAR_POS_W-1:0] char_pos;
		logic [BYTE_W-1:0]     byte_value;
		logic [LEN_W-1:0]      len;
	} cell_cmd_t;

	typedef struct packed {
		logic             hit;
		logic [LEN_W-1:0] len;
	} cell_stat_t;

	typedef struct packed {
		logic             vld;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] idx;
	} cand_t;
endpackage
`default_nettype wire

/* rtl/kwm_ifs.sv */
// Valid/ready channel interfaces for text/load items and match results.
`default_nettype none
interface kwm_in_if import kwm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     kind;
	logic [SLOT_W-1:0]     key_slot;
	logic [CHAR_POS_W-1:0] char_pos;
	logic [BYTE_W-1:0]     byte_value;
	logic [KEY_LEN_W-1:0]  key_len;
	logic                  start_of_text;

	modport source (output valid, kind, key_slot, char_pos, byte_value, key_len,
		start_of_text, input ready);
	modport sink (input valid, kind, key_slot, char_pos, byte_value, key_len,
		start_of_text, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KEY_INDEX_W-1:0] key_index;
	logic [MATCH_W-1:0]     match_start;
	logic [MATCH_W-1:0]     match_end;

	modport source (output valid, key_index, match_start, match_end, input ready);
	modport sink (input valid, key_index, match_start, match_end, output ready);
endinterface
`default_nettype wire

/* rtl/kwm_cell.sv */
// One keyword slot: stored bytes, length and shift-and partial match vector.
`default_nettype none
`include "assert_macros.svh"
module kwm_cell import kwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  logic       sel,
	input  logic       active,
	input  logic       clear_all,
	output cell_stat_t stat
);
	logic [BYTE_W-1:0]      kbyte_q [MAX_KEY_LEN];
	logic [LEN_W-1:0]       len_q;
	logic [MAX_KEY_LEN-1:0] partial_q;

	logic [MAX_KEY_LEN-1:0] lenmask;
	logic [MAX_KEY_LEN-1:0] lastmask;
	logic [MAX_KEY_LEN-1:0] eq;
	logic [MAX_KEY_LEN-1:0] part_eff;
	logic [MAX_KEY_LEN-1:0] alive;
	logic [MAX_KEY_LEN-1:0] part_nxt;

	always_comb begin
		for (int j = 0; j < MAX_KEY_LEN; j++) begin
			lenmask[j]  = LEN_W'(j) < len_q;
			lastmask[j] = LEN_W'(j + 1) == len_q;
			eq[j]       = kbyte_q[j] == cmd.byte_value;
		end
		part_eff = cmd.sot ? '0 : partial_q;
		// bit 0 always armed: every text byte may start a match
		alive    = (part_eff | MAX_KEY_LEN'(1)) & eq & lenmask;
		part_nxt = (alive << 1) & lenmask;
	end

	assign stat.hit = active && (|(alive & lastmask));
	assign stat.len = len_q;

	always_ff @(posedge clk) begin
		if (cmd.key_wr && sel) begin
			for (int j = 0; j < MAX_KEY_LEN; j++) begin
				if (32'(cmd.char_pos) == j) begin
					kbyte_q[j] <= cmd.byte_value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			partial_q <= '0;
		end else if (cmd.len_wr && sel) begin
			len_q     <= cmd.len;
			partial_q <= '0;
		end else if (cmd.text) begin
			partial_q <= (clear_all || !active) ? '0 : part_nxt;
		end
	end

	`KWM_ASSERT(a_len_wr_clears, cmd.len_wr && sel |=> partial_q == '0, "length write left partials")
	`KWM_ASSERT(a_hit_clears, cmd.text && clear_all |=> partial_q == '0, "hit did not clear partials")
	`KWM_ASSERT(a_within_len, (partial_q & ~lenmask) == '0, "partial bit beyond keyword length")
endmodule
`default_nettype wire

/* rtl/kwm_pick.sv */
// Registered selection tree: shortest hit keyword, lowest slot on a tie, plus output register.
`default_nettype none
module kwm_pick import kwm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   leaf_vld,
	input  cell_stat_t             stat [NUM_KEYS],
	input  logic [POS_WIDTH-1:0]   pos,
	output logic                   out_vld,
	output logic [KEY_INDEX_W-1:0] key_index,
	output logic [MATCH_W-1:0]     match_start,
	output logic [MATCH_W-1:0]     match_end
);
	// heap layout: node 0 is the root, leaves start at LEAVES-1
	cand_t                node_s [2*LEAVES-1];
	logic                 vld_s  [TREE_LVLS+1];
	logic [POS_WIDTH-1:0] pos_s  [TREE_LVLS+1];

	logic                   out_vld_q;
	logic [KEY_INDEX_W-1:0] key_index_q;
	logic [MATCH_W-1:0]     match_start_q;
	logic [MATCH_W-1:0]     match_end_q;

	// left child always holds the lower slots
	function automatic cand_t better(input cand_t a, input cand_t b);
		cand_t r;
		r = (b.vld && (!a.vld || b.len < a.len)) ? b : a;
		return r;
	endfunction

	genvar n;
	for (n = 0; n < 2*LEAVES-1; n++) begin : g_node
		if (n >= LEAVES - 1) begin : g_leaf
			if (n - (LEAVES - 1) < NUM_KEYS) begin : g_used
				always_ff @(posedge clk) begin
					if (adv) begin
						node_s[n].vld <= stat[n-(LEAVES-1)].hit;
						node_s[n].len <= stat[n-(LEAVES-1)].len;
						node_s[n].idx <= IDX_W'(n - (LEAVES - 1));
					end
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					if (adv) begin
						node_s[n] <= '0;
					end
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (adv) begin
					node_s[n] <= better(node_s[2*n+1], node_s[2*n+2]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= TREE_LVLS; l++) begin
				vld_s[l] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= leaf_vld;
			for (int l = 1; l <= TREE_LVLS; l++) begin
				vld_s[l] <= vld_s[l-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s[0] <= pos;
			for (int l = 1; l <= TREE_LVLS; l++) begin
				pos_s[l] <= pos_s[l-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[TREE_LVLS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_index_q   <= KEY_INDEX_W'(node_s[0].idx);
			match_start_q <= MATCH_W'(pos_s[TREE_LVLS] - POS_WIDTH'(node_s[0].len)
				+ POS_WIDTH'(1));
			match_end_q   <= MATCH_W'(pos_s[TREE_LVLS] + POS_WIDTH'(1));
		end
	end

	assign out_vld     = out_vld_q;
	assign key_index   = key_index_q;
	assign match_start = match_start_q;
	assign match_end   = match_end_q;
endmodule
`default_nettype wire

/* rtl/multi_keyword_stream_matcher_top.sv */
// Top level of the multi-keyword stream matcher: cell row, position counter, config.
//
//  channel  dir  transaction        payload
//  stream   in   valid & ready      kind, key_slot, char_pos, byte_value, key_len,
//                                   start_of_text
//  hits     out  valid & ready      key_index, match_start, match_end
//  cfg      in   cfg_we             cfg_wdata = keys_in_use
//
// One transaction per cycle on stream, sustained while hits is not stalled. A hit leaves
// on hits after its text byte has passed the leaf register,
// one register per tree level and the output register.
// The per-byte rate is set by the cell row: compare, OR of all hits, clear.
// Reset clears lengths, partials, position and keys_in_use; keyword bytes are not reset.
// While a result waits on hits the whole pipe holds and stream.ready is low.
`default_nettype none
`include "assert_macros.svh"
module multi_keyword_stream_matcher_top import kwm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	kwm_in_if.sink           stream,
	kwm_out_if.source        hits
);
	logic [CFG_W-1:0]     keys_in_use_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] pos_eff;
	logic                 adv;
	logic                 acc;
	logic                 hit_any;
	logic [NUM_KEYS-1:0]  hit_vec;
	cell_cmd_t            cmd;
	cell_stat_t           stat [NUM_KEYS];

	assign adv          = !hits.valid || hits.ready;
	assign stream.ready = adv;
	assign acc          = stream.valid && adv;

	always_comb begin
		cmd.key_wr     = acc && (stream.kind == KIND_KEY_BYTE)
			&& (32'(stream.char_pos) < MAX_KEY_LEN);
		cmd.len_wr     = acc && (stream.kind == KIND_KEY_LEN);
		cmd.text       = acc && (stream.kind == KIND_TEXT);
		cmd.sot        = stream.start_of_text;
		cmd.char_pos   = stream.char_pos;
		cmd.byte_value = stream.byte_value;
		cmd.len        = (32'(stream.key_len) > MAX_KEY_LEN) ? LEN_W'(MAX_KEY_LEN)
			: LEN_W'(stream.key_len);
	end

	assign pos_eff = stream.start_of_text ? '0 : pos_q;
	assign hit_any = |hit_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_in_use_q <= '0;
		end else if (cfg_we) begin
			keys_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.text) begin
			pos_q <= pos_eff + POS_WIDTH'(1);
		end
	end

	genvar i;
	for (i = 0; i < NUM_KEYS; i++) begin : g_cell
		kwm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (32'(stream.key_slot) == i),
			.active    (32'(keys_in_use_q) > i),
			.clear_all (hit_any),
			.stat      (stat[i])
		);
		assign hit_vec[i] = stat[i].hit;
	end

	kwm_pick u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.leaf_vld    (cmd.text && hit_any),
		.stat        (stat),
		.pos         (pos_eff),
		.out_vld     (hits.valid),
		.key_index   (hits.key_index),
		.match_start (hits.match_start),
		.match_end   (hits.match_end)
	);

	`KWM_ASSERT_ALWAYS(a_no_slots_no_hit, keys_in_use_q == '0 |-> !hit_any, "hit with no slot in use")
	`KWM_ASSERT(a_sot_restart, cmd.text && cmd.sot |=> pos_q == POS_WIDTH'(1), "position not restarted")
	`KWM_ASSERT(a_stall_holds_pos, !stream.ready |=> $stable(pos_q), "position moved while stalled")
endmodule
`default_nettype wire

/* tb/sv/tb_multi_keyword_stream_matcher_top.sv */
// Self-checking testbench for the multi-keyword stream matcher top level.
module tb_multi_keyword_stream_matcher_top;
	import kwm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
	localparam int DRAIN_CYCLES = TREE_LVLS + 8;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [SLOT_W-1:0]     key_slot;
		logic [CHAR_POS_W-1:0] char_pos;
		logic [BYTE_W-1:0]     byte_value;
		logic [KEY_LEN_W-1:0]  key_len;
		logic                  start_of_text;
	} stream_item_t;

	localparam int ITEM_W = $bits(stream_item_t);

	typedef struct packed {
		logic [KEY_INDEX_W-1:0] key_index;
		logic [MATCH_W-1:0]     match_start;
		logic [MATCH_W-1:0]     match_end;
	} match_t;

	typedef struct packed {
		bit               is_cfg;
		logic [CFG_W-1:0] cfg_val;
		stream_item_t     item;
		bit               fixed;
		bit               want_hit;
		match_t           want;
	} directed_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	kwm_in_if  stream ();
	kwm_out_if hits ();

	multi_keyword_stream_matcher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream),
		.hits      (hits)
	);

	// Matcher image kept by the testbench
	logic [BYTE_W-1:0]      kw_bytes [NUM_KEYS][MAX_KEY_LEN];
	bit                     kw_written [NUM_KEYS][MAX_KEY_LEN] = '{default: '0};
	logic [KEY_LEN_W-1:0]   kw_len [NUM_KEYS] = '{default: '0};
	logic [MAX_KEY_LEN-1:0] kw_partial [NUM_KEYS] = '{default: '0};
	logic [POS_WIDTH-1:0]   text_pos = '0;
	logic [CFG_W-1:0]       slots_in_use = '0;

	match_t pending_hits [$];
	int     mismatches = 0;
	int     items_sent = 0;
	int     send_burst_left = 0;
	int     cycle_count = 0;

	match_t      rx_want;
	logic [31:0] rx_cycle = '0;
	int          rx_stall_left = 0;

	directed_step_t plan [25];
	int             slot_settings [7];

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d hits still pending", $time, pending_hits.size());
			$display("FAIL");
			$finish;
		end
	end

	// Advances the matcher image by one accepted transaction; returns 1 on a hit.
	function automatic bit step_matcher(input stream_item_t it, output match_t found);
		int active;
		int best_len;
		int best_slot;
		bit hit;
		logic [MAX_KEY_LEN-1:0] eq;
		logic [MAX_KEY_LEN-1:0] alive;
		logic [MAX_KEY_LEN:0]   lmask;
		found = '0;
		hit = 1'b0;
		best_len = 0;
		best_slot = 0;
		case (it.kind)
			KIND_KEY_BYTE: begin
				kw_bytes[it.key_slot][it.char_pos] = it.byte_value;
				kw_written[it.key_slot][it.char_pos] = 1'b1;
			end
			KIND_KEY_LEN: begin
				kw_len[it.key_slot] = (it.key_len > MAX_KEY_LEN) ?
					KEY_LEN_W'(MAX_KEY_LEN) : it.key_len;
				kw_partial[it.key_slot] = '0;
			end
			KIND_TEXT: begin
				if (it.start_of_text) begin
					kw_partial = '{default: '0};
					text_pos = '0;
				end
				active = (slots_in_use > NUM_KEYS) ? NUM_KEYS : int'(slots_in_use);
				for (int i = 0; i < NUM_KEYS; i++) begin
					if (i >= active || kw_len[i] == 0) begin
						kw_partial[i] = '0;
						continue;
					end
					eq = '0;
					for (int j = 0; j < kw_len[i]; j++)
						if (kw_bytes[i][j] == it.byte_value)
							eq[j] = 1'b1;
					alive = (kw_partial[i] | MAX_KEY_LEN'(1)) & eq;
					// shortest wins, strict compare keeps the lowest slot on a tie
					if (alive[kw_len[i] - 1] && (!hit || int'(kw_len[i]) < best_len)) begin
						hit = 1'b1;
						best_slot = i;
						best_len = int'(kw_len[i]);
					end
					lmask = (MAX_KEY_LEN + 1)'((1 << kw_len[i]) - 1);
					kw_partial[i] = (alive << 1) & lmask[MAX_KEY_LEN-1:0];
				end
				if (hit) begin
					found.key_index = KEY_INDEX_W'(best_slot);
					found.match_start = text_pos - POS_WIDTH'(best_len - 1);
					found.match_end = text_pos + 1'b1;
					kw_partial = '{default: '0};
				end
				text_pos = text_pos + 1'b1;
			end
			default: ;
		endcase
		return hit;
	endfunction

	function automatic stream_item_t mk_key_byte(input int slot, input int pos, input int b);
		stream_item_t it;
		it = ITEM_W'($urandom);
		it.kind = KIND_KEY_BYTE;
		it.key_slot = SLOT_W'(slot);
		it.char_pos = CHAR_POS_W'(pos);
		it.byte_value = BYTE_W'(b);
		return it;
	endfunction

	function automatic stream_item_t mk_key_len(input int slot, input int len);
		stream_item_t it;
		it = ITEM_W'($urandom);
		it.kind = KIND_KEY_LEN;
		it.key_slot = SLOT_W'(slot);
		it.key_len = KEY_LEN_W'(len);
		return it;
	endfunction

	function automatic stream_item_t mk_text(input logic [BYTE_W-1:0] b, input bit sot);
		stream_item_t it;
		it = ITEM_W'($urandom);
		it.kind = KIND_TEXT;
		it.byte_value = b;
		it.start_of_text = sot;
		return it;
	endfunction

	function automatic directed_step_t row_cfg(input int v);
		directed_step_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_val = CFG_W'(v);
		return r;
	endfunction

	function automatic directed_step_t row_chk(input stream_item_t it);
		directed_step_t r;
		r = '0;
		r.item = it;
		return r;
	endfunction

	function automatic directed_step_t row_none(input stream_item_t it);
		directed_step_t r;
		r = '0;
		r.item = it;
		r.fixed = 1'b1;
		return r;
	endfunction

	function automatic directed_step_t row_hit(input stream_item_t it, input int idx,
			input int s, input int e);
		directed_step_t r;
		r = '0;
		r.item = it;
		r.fixed = 1'b1;
		r.want_hit = 1'b1;
		r.want.key_index = KEY_INDEX_W'(idx);
		r.want.match_start = MATCH_W'(s);
		r.want.match_end = MATCH_W'(e);
		return r;
	endfunction

	// Small alphabet most of the time so that short keywords hit often
	function automatic int pick_char();
		if ($urandom_range(0, 19) < 17)
			return "a" + $urandom_range(0, 3);
		return $urandom_range(0, 255);
	endfunction

	function automatic int pick_slot();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, NUM_KEYS - 1);
		return $urandom_range(0, 7);
	endfunction

	task automatic send_item(input stream_item_t it, input bit typed = 1'b0,
			input bit typed_hit = 1'b0, input match_t typed_res = '0);
		int gap;
		bit hit;
		match_t m;
		if (send_burst_left == 0) begin
			send_burst_left = $urandom_range(1, 32);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: gap = 0;
				5: gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				stream.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		send_burst_left--;
		stream.valid <= 1'b1;
		stream.kind <= it.kind;
		stream.key_slot <= it.key_slot;
		stream.char_pos <= it.char_pos;
		stream.byte_value <= it.byte_value;
		stream.key_len <= it.key_len;
		stream.start_of_text <= it.start_of_text;
		do @(posedge clk); while (!stream.ready);
		hit = step_matcher(it, m);
		if (typed) begin
			hit = typed_hit;
			m = typed_res;
		end
		if (hit)
			pending_hits.push_back(m);
		if (it.kind != KIND_RESERVED)
			items_sent++;
	endtask

	// Register write with the pipe drained, so no text byte sees a mixed setting
	task automatic load_slots_in_use(input logic [CFG_W-1:0] v);
		stream.valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		slots_in_use = v;
	endtask

	always @(posedge clk) begin
		if (arst_n && hits.valid && hits.ready) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected hit: slot %0d start %0d end %0d", $time,
					hits.key_index, hits.match_start, hits.match_end);
				mismatches++;
			end else begin
				rx_want = pending_hits.pop_front();
				if (hits.key_index !== rx_want.key_index) begin
					$display("%0t: key_index expected %0d got %0d", $time,
						rx_want.key_index, hits.key_index);
					mismatches++;
				end
				if (hits.match_start !== rx_want.match_start) begin
					$display("%0t: match_start expected %0d got %0d", $time,
						rx_want.match_start, hits.match_start);
					mismatches++;
				end
				if (hits.match_end !== rx_want.match_end) begin
					$display("%0t: match_end expected %0d got %0d", $time,
						rx_want.match_end, hits.match_end);
					mismatches++;
				end
			end
		end
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[9:8])
			2'd0: hits.ready <= 1'b1;
			2'd1: hits.ready <= ($urandom_range(0, 9) < 7);
			2'd2: begin
				if (rx_stall_left > 0) begin
					rx_stall_left--;
					hits.ready <= 1'b0;
				end else begin
					hits.ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						rx_stall_left = $urandom_range(3, 15);
				end
			end
			default: hits.ready <= rx_cycle[1];
		endcase
	end

	initial begin
		int slot;
		int klen;
		int lenv;
		int goal;
		int r;
		int n;
		bit sot;
		stream.valid <= 1'b0;
		stream.kind <= KIND_KEY_BYTE;
		stream.key_slot <= '0;
		stream.char_pos <= '0;
		stream.byte_value <= '0;
		stream.key_len <= '0;
		stream.start_of_text <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			// no slots in use after reset
			row_none(mk_text("a", 1'b1)),
			row_cfg(NUM_KEYS),
			row_chk(mk_key_byte(0, 0, "a")),
			row_chk(mk_key_byte(0, 1, "b")),
			row_chk(mk_key_len(0, 2)),
			row_chk(mk_key_byte(NUM_KEYS - 1, MAX_KEY_LEN - 1, 255)),
			// overlong length, disabled again before any text byte reads it
			row_chk(mk_key_len(1, 31)),
			row_chk(mk_key_len(1, 0)),
			row_chk('1),
			row_chk(mk_text("a", 1'b1)),
			row_hit(mk_text("b", 1'b0), 0, 0, 2),
			row_chk(mk_key_byte(2, 0, "b")),
			row_chk(mk_key_len(2, 1)),
			row_chk(mk_text("a", 1'b1)),
			// "ab" and "b" both complete: shorter one wins
			row_hit(mk_text("b", 1'b0), 2, 1, 2),
			row_chk(mk_key_byte(3, 0, "b")),
			row_chk(mk_key_len(3, 1)),
			// equal lengths: lower slot wins
			row_hit(mk_text("b", 1'b1), 2, 0, 1),
			row_chk(mk_text("a", 1'b0)),
			// rewriting the length drops the pending "a"
			row_chk(mk_key_len(0, 2)),
			row_hit(mk_text("b", 1'b0), 2, 2, 3),
			row_cfg(1),
			row_none(mk_text("b", 1'b1)),
			row_chk(mk_text("a", 1'b0)),
			row_hit(mk_text("b", 1'b0), 0, 1, 3)
		};
		foreach (plan[k]) begin
			if (plan[k].is_cfg)
				load_slots_in_use(plan[k].cfg_val);
			else
				send_item(plan[k].item, plan[k].fixed, plan[k].want_hit, plan[k].want);
		end

		slot_settings = '{NUM_KEYS, 63, 1, 0, NUM_KEYS + 1, $urandom_range(2, NUM_KEYS - 1),
			NUM_KEYS};
		foreach (slot_settings[p]) begin
			load_slots_in_use(CFG_W'(slot_settings[p]));
			goal = items_sent + ((slot_settings[p] == 0) ? 60 : 200);
			while (items_sent < goal) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					slot = pick_slot();
					klen = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) :
						$urandom_range(5, MAX_KEY_LEN);
					for (int j = 0; j < klen; j++)
						send_item(mk_key_byte(slot, j, pick_char()));
					lenv = (klen == MAX_KEY_LEN && $urandom_range(0, 1) == 1) ?
						$urandom_range(MAX_KEY_LEN, 31) : klen;
					send_item(mk_key_len(slot, lenv));
				end else if (r < 17) begin
					send_item(mk_key_len(pick_slot(), 0));
				end else if (r < 22) begin
					// any length, but only over keyword bytes that exist
					slot = $urandom_range(0, NUM_KEYS - 1);
					lenv = $urandom_range(0, 31);
					klen = (lenv > MAX_KEY_LEN) ? MAX_KEY_LEN : lenv;
					for (int j = 0; j < klen; j++)
						if (!kw_written[slot][j])
							send_item(mk_key_byte(slot, j, pick_char()));
					send_item(mk_key_len(slot, lenv));
				end else if (r < 27) begin
					send_item(mk_key_byte($urandom_range(0, NUM_KEYS - 1),
						$urandom_range(0, MAX_KEY_LEN - 1), $urandom_range(0, 255)));
				end else if (r < 30) begin
					send_item({KIND_RESERVED, SLOT_W'($urandom), CHAR_POS_W'($urandom),
						BYTE_W'($urandom), KEY_LEN_W'($urandom), 1'($urandom)});
				end else begin
					n = $urandom_range(1, 12);
					for (int j = 0; j < n; j++) begin
						sot = (j == 0 && $urandom_range(0, 2) == 0) ||
							$urandom_range(0, 19) == 0;
						send_item(mk_text(BYTE_W'(pick_char()), sot));
					end
				end
			end
		end

		stream.valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
